>>> src/hlba_pkg.sv
// Package for the hole-list block allocator: sizes, pointer codes, memory entry
// types and the sequencer state encoding.
// No dependencies.
`default_nettype none

package hlba_pkg;

	// Area geometry.
	localparam int AREA_WORDS     = 4096;
	localparam int BYTES_PER_WORD = 8;
	localparam int GRANULES       = AREA_WORDS / 2;
	localparam int GRAN_BYTES     = 2 * BYTES_PER_WORD;
	localparam int GRAN_SHIFT     = $clog2(GRAN_BYTES);

	// Field widths.
	localparam int PTR_W  = 12;
	localparam int SIZE_W = 13;
	localparam int RSZ_W  = 14;
	localparam int CNT_W  = 12;
	localparam int IDX_W  = $clog2(GRANULES);

	// Holes always start on an even word, so the odd all-ones pointer marks an empty link.
	localparam logic [PTR_W-1:0] NULL_PTR = {PTR_W{1'b1}};

	// Operation codes.
	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_REORG = 2'd2;

	// One hole descriptor, stored per granule.
	typedef struct packed {
		logic [PTR_W-1:0]  next;
		logic [SIZE_W-1:0] size;
	} hole_t;

	// One entry of the scratch list used while reorganizing.
	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic [PTR_W-1:0]  addr;
	} gath_t;

	// Which list the gather walk is on.
	typedef enum logic [2:0] {
		LS_FREED   = 3'b001,
		LS_DROPPED = 3'b010,
		LS_READY   = 3'b100
	} list_t;

	// Sequencer states.
	typedef enum logic [23:0] {
		ST_IDLE     = 24'h000001,
		ST_EXEC     = 24'h000002,
		ST_AL_READY = 24'h000004,
		ST_AL_FREED = 24'h000008,
		ST_FR_FREED = 24'h000010,
		ST_G_CHK    = 24'h000020,
		ST_G_NEXT   = 24'h000040,
		ST_SO_RDI   = 24'h000080,
		ST_SO_V     = 24'h000100,
		ST_SO_CMP   = 24'h000200,
		ST_SO_PUT   = 24'h000400,
		ST_MG_RD0   = 24'h000800,
		ST_MG_K0    = 24'h001000,
		ST_MG_K1    = 24'h002000,
		ST_MG_RDI   = 24'h004000,
		ST_MG_P     = 24'h008000,
		ST_MG_PD    = 24'h010000,
		ST_SF_RDI   = 24'h020000,
		ST_SF_A     = 24'h040000,
		ST_SF_W     = 24'h080000,
		ST_BD_RD    = 24'h100000,
		ST_BD_W     = 24'h200000,
		ST_RES_RD   = 24'h400000,
		ST_RES      = 24'h800000
	} state_t;

endpackage

`default_nettype wire

>>> src/hole_list_block_allocator_unit.sv
// Hole-list block allocator: sequencer around a hole descriptor memory and a
// scratch memory for reorganizing. Depends on hlba_pkg.
// The next transfer is taken in the cycle after the result is loaded. A reorganize
// walks the freed, dropped and ready lists into the scratch memory, insertion-sorts
// the entries by address, merges holes that touch, attaches each merged hole's size,
// insertion-sorts by size and rebuilds the ready list, each pass paced by the single
// read port of each memory. One item is in work at a time; a finished result waits
// in the output register while the next item is taken. Reset clears all control
// registers; the memories are not cleared and need no clearing pass.
`default_nettype none

module hole_list_block_allocator_unit (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire  [1:0]                   op,
	input  wire  [15:0]                  size_bytes,
	input  wire  [hlba_pkg::PTR_W-1:0]   block_address,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic                         ok,
	output logic [hlba_pkg::PTR_W-1:0]   address,
	output logic [15:0]                  largest_free_bytes,
	output logic [hlba_pkg::SIZE_W-1:0]  used_words,
	output logic [hlba_pkg::CNT_W-1:0]   hole_count,
	input  wire                          cfg_write_enable,
	input  wire  [hlba_pkg::SIZE_W-1:0]  cfg_write_data
);

	localparam int PW = hlba_pkg::PTR_W;
	localparam int SW = hlba_pkg::SIZE_W;
	localparam int RW = hlba_pkg::RSZ_W;
	localparam int CW = hlba_pkg::CNT_W;
	localparam int IW = hlba_pkg::IDX_W;

	// Memories.
	hlba_pkg::hole_t hole_mem [hlba_pkg::GRANULES];
	hlba_pkg::gath_t gath_mem [hlba_pkg::GRANULES];
	hlba_pkg::hole_t hole_rd_q;
	hlba_pkg::gath_t gath_rd_q;

	logic            hole_re, hole_we, gath_re, gath_we;
	logic [IW-1:0]   hole_raddr, hole_waddr, gath_raddr, gath_waddr;
	hlba_pkg::hole_t hole_wdata;
	hlba_pkg::gath_t gath_wdata;

	// Control and allocator registers.
	hlba_pkg::state_t state_q, state_d;
	hlba_pkg::list_t  list_q, list_d;
	logic [1:0]    op_q, op_d;
	logic [RW-1:0] rsz_q, rsz_d;
	logic [PW-1:0] pos_q, pos_d;
	logic [SW-1:0] area_q;
	logic [PW-1:0] bump_base_q, bump_base_d;
	logic [SW-1:0] bump_size_q, bump_size_d;
	logic [PW-1:0] ready_q, ready_d, freed_q, freed_d, dropped_q, dropped_d;
	logic [SW-1:0] used_q, used_d;
	logic [CW-1:0] kept_q, kept_d;
	logic          res_ok_q, res_ok_d;
	logic [PW-1:0] res_addr_q, res_addr_d;
	logic [PW-1:0] walk_q, walk_d;
	logic [CW-1:0] gcount_q, gcount_d, i_q, i_d, j_q, j_d, n_q, n_d;
	hlba_pkg::gath_t v_q, v_d;
	logic [PW-1:0] k_q, k_d, p_q, p_d, knext_q, knext_d;
	logic [SW-1:0] l_q, l_d;
	logic          by_size_q, by_size_d;

	// Output register.
	logic          out_valid_q;
	logic          out_load;
	logic          ok_q;
	logic [PW-1:0] address_q;
	logic [15:0]   largest_q;
	logic [SW-1:0] used_out_q;
	logic [CW-1:0] kept_out_q;

	logic [16:0]   bsum;
	logic [RW-1:0] rsz_in;
	logic [SW-1:0] cfg_area;
	logic [SW-1:0] largest_w;
	logic [15:0]   largest_bytes;

	// Request size rounded up to whole granules, in words.
	assign bsum   = {1'b0, size_bytes} + 17'(hlba_pkg::GRAN_BYTES - 1);
	assign rsz_in = RW'({bsum >> hlba_pkg::GRAN_SHIFT, 1'b0});

	// Area size clamped to the area and rounded down to even.
	always_comb begin
		if (cfg_write_data > SW'(hlba_pkg::AREA_WORDS)) begin
			cfg_area = SW'(hlba_pkg::AREA_WORDS);
		end else begin
			cfg_area = cfg_write_data;
		end
		cfg_area[0] = 1'b0;
	end

	// Larger of the bump hole and the ready head.
	always_comb begin
		largest_w = bump_size_q;
		if (ready_q != hlba_pkg::NULL_PTR && hole_rd_q.size > bump_size_q) begin
			largest_w = hole_rd_q.size;
		end
		largest_bytes = 16'(largest_w) * 16'(hlba_pkg::BYTES_PER_WORD);
	end

	assign in_stall = (state_q != hlba_pkg::ST_IDLE);

	// Sequencer: next state, register updates and memory ports.
	always_comb begin
		logic [SW-1:0] bs;
		logic [SW-1:0] rem;
		logic [PW-1:0] nf;
		logic          bad;
		logic          ahead;
		hlba_pkg::gath_t e;

		bs = '0;
		rem = '0;
		nf = '0;
		bad = 1'b0;
		ahead = 1'b0;
		e = gath_rd_q;

		state_d = state_q;
		list_d = list_q;
		op_d = op_q;
		rsz_d = rsz_q;
		pos_d = pos_q;
		bump_base_d = bump_base_q;
		bump_size_d = bump_size_q;
		ready_d = ready_q;
		freed_d = freed_q;
		dropped_d = dropped_q;
		used_d = used_q;
		kept_d = kept_q;
		res_ok_d = res_ok_q;
		res_addr_d = res_addr_q;
		walk_d = walk_q;
		gcount_d = gcount_q;
		i_d = i_q;
		j_d = j_q;
		n_d = n_q;
		v_d = v_q;
		k_d = k_q;
		p_d = p_q;
		knext_d = knext_q;
		l_d = l_q;
		by_size_d = by_size_q;
		out_load = 1'b0;

		hole_re = 1'b0;
		hole_raddr = '0;
		hole_we = 1'b0;
		hole_waddr = '0;
		hole_wdata = '0;
		gath_re = 1'b0;
		gath_raddr = '0;
		gath_we = 1'b0;
		gath_waddr = '0;
		gath_wdata = '0;

		unique case (state_q)
			hlba_pkg::ST_IDLE: begin
				if (in_valid) begin
					op_d = op;
					rsz_d = rsz_in;
					pos_d = block_address;
					res_ok_d = 1'b0;
					res_addr_d = '0;
					state_d = hlba_pkg::ST_EXEC;
				end
			end

			hlba_pkg::ST_EXEC: begin
				state_d = hlba_pkg::ST_RES_RD;
				case (op_q)
					hlba_pkg::OP_ALLOC: begin
						if (rsz_q == '0) begin
							state_d = hlba_pkg::ST_RES_RD;
						end else if (rsz_q <= RW'(bump_size_q)) begin
							// Cut from the top of the bump hole.
							bs = bump_size_q - rsz_q[SW-1:0];
							bump_size_d = bs;
							res_addr_d = bump_base_q + bs[PW-1:0];
							used_d = used_q + rsz_q[SW-1:0];
							res_ok_d = 1'b1;
						end else if (ready_q != hlba_pkg::NULL_PTR) begin
							hole_re = 1'b1;
							hole_raddr = ready_q[PW-1:1];
							state_d = hlba_pkg::ST_AL_READY;
						end else if (freed_q != hlba_pkg::NULL_PTR) begin
							hole_re = 1'b1;
							hole_raddr = freed_q[PW-1:1];
							state_d = hlba_pkg::ST_AL_FREED;
						end
					end
					hlba_pkg::OP_FREE: begin
						bad = pos_q[0] || (SW'(pos_q) >= area_q) || (rsz_q == '0)
							|| ((15'(pos_q) + 15'(rsz_q)) > 15'(area_q))
							|| (rsz_q > RW'(used_q));
						if (!bad) begin
							used_d = used_q - rsz_q[SW-1:0];
							res_ok_d = 1'b1;
							if ((14'(bump_base_q) + 14'(bump_size_q)) == 14'(pos_q)) begin
								// Freed block sits right above the bump hole.
								bump_size_d = bump_size_q + rsz_q[SW-1:0];
							end else if (freed_q != hlba_pkg::NULL_PTR) begin
								hole_re = 1'b1;
								hole_raddr = freed_q[PW-1:1];
								state_d = hlba_pkg::ST_FR_FREED;
							end else begin
								hole_we = 1'b1;
								hole_waddr = pos_q[PW-1:1];
								hole_wdata = '{next: freed_q, size: rsz_q[SW-1:0]};
								freed_d = pos_q;
								kept_d = kept_q + 1'b1;
							end
						end
					end
					hlba_pkg::OP_REORG: begin
						gcount_d = '0;
						walk_d = freed_q;
						list_d = hlba_pkg::LS_FREED;
						state_d = hlba_pkg::ST_G_CHK;
					end
					default: begin
						state_d = hlba_pkg::ST_RES_RD;
					end
				endcase
			end

			hlba_pkg::ST_AL_READY: begin
				state_d = hlba_pkg::ST_RES_RD;
				if (RW'(hole_rd_q.size) >= rsz_q) begin
					res_ok_d = 1'b1;
					used_d = used_q + rsz_q[SW-1:0];
					ready_d = hole_rd_q.next;
					if (RW'(hole_rd_q.size) == rsz_q) begin
						// Exact fit: the ready head goes whole.
						res_addr_d = ready_q;
						kept_d = kept_q - 1'b1;
					end else begin
						// Retire the bump hole and cut from the ready head's top.
						if (bump_size_q != '0) begin
							hole_we = 1'b1;
							hole_waddr = bump_base_q[PW-1:1];
							hole_wdata = '{next: dropped_q, size: bump_size_q};
							dropped_d = bump_base_q;
						end else begin
							kept_d = kept_q - 1'b1;
						end
						bs = hole_rd_q.size - rsz_q[SW-1:0];
						bump_base_d = ready_q;
						bump_size_d = bs;
						res_addr_d = ready_q + bs[PW-1:0];
					end
				end else if (freed_q != hlba_pkg::NULL_PTR) begin
					hole_re = 1'b1;
					hole_raddr = freed_q[PW-1:1];
					state_d = hlba_pkg::ST_AL_FREED;
				end
			end

			hlba_pkg::ST_AL_FREED: begin
				state_d = hlba_pkg::ST_RES_RD;
				if (RW'(hole_rd_q.size) >= rsz_q) begin
					// Cut from the low end of the newest freed hole.
					res_ok_d = 1'b1;
					res_addr_d = freed_q;
					used_d = used_q + rsz_q[SW-1:0];
					rem = hole_rd_q.size - rsz_q[SW-1:0];
					if (rem != '0) begin
						nf = freed_q + rsz_q[PW-1:0];
						freed_d = nf;
						hole_we = 1'b1;
						hole_waddr = nf[PW-1:1];
						hole_wdata = '{next: hole_rd_q.next, size: rem};
					end else begin
						freed_d = hole_rd_q.next;
						kept_d = kept_q - 1'b1;
					end
				end
			end

			hlba_pkg::ST_FR_FREED: begin
				state_d = hlba_pkg::ST_RES_RD;
				hole_we = 1'b1;
				if ((15'(pos_q) + 15'(rsz_q)) == 15'(freed_q)) begin
					// Block ends where the freed head starts.
					hole_waddr = pos_q[PW-1:1];
					hole_wdata = '{next: hole_rd_q.next,
						size: hole_rd_q.size + rsz_q[SW-1:0]};
					freed_d = pos_q;
				end else if ((14'(freed_q) + 14'(hole_rd_q.size)) == 14'(pos_q)) begin
					// Block starts where the freed head ends.
					hole_waddr = freed_q[PW-1:1];
					hole_wdata = '{next: hole_rd_q.next,
						size: hole_rd_q.size + rsz_q[SW-1:0]};
				end else begin
					hole_waddr = pos_q[PW-1:1];
					hole_wdata = '{next: freed_q, size: rsz_q[SW-1:0]};
					freed_d = pos_q;
					kept_d = kept_q + 1'b1;
				end
			end

			// Gather the freed, dropped and ready lists into the scratch memory.
			hlba_pkg::ST_G_CHK: begin
				if (walk_q != hlba_pkg::NULL_PTR && gcount_q != CW'(hlba_pkg::GRANULES)) begin
					gath_we = 1'b1;
					gath_waddr = gcount_q[IW-1:0];
					gath_wdata = '{size: '0, addr: walk_q};
					gcount_d = gcount_q + 1'b1;
					hole_re = 1'b1;
					hole_raddr = walk_q[PW-1:1];
					state_d = hlba_pkg::ST_G_NEXT;
				end else begin
					unique case (list_q)
						hlba_pkg::LS_FREED: begin
							walk_d = dropped_q;
							list_d = hlba_pkg::LS_DROPPED;
						end
						hlba_pkg::LS_DROPPED: begin
							if (gcount_q == '0) begin
								state_d = hlba_pkg::ST_RES_RD;
							end else begin
								walk_d = ready_q;
								list_d = hlba_pkg::LS_READY;
							end
						end
						hlba_pkg::LS_READY: begin
							ready_d = hlba_pkg::NULL_PTR;
							freed_d = hlba_pkg::NULL_PTR;
							dropped_d = hlba_pkg::NULL_PTR;
							kept_d = '0;
							i_d = CW'(1);
							by_size_d = 1'b0;
							state_d = hlba_pkg::ST_SO_RDI;
						end
						default: begin
							state_d = hlba_pkg::ST_RES_RD;
						end
					endcase
				end
			end

			hlba_pkg::ST_G_NEXT: begin
				walk_d = hole_rd_q.next;
				state_d = hlba_pkg::ST_G_CHK;
			end

			// Insertion sort over the scratch memory, by address or by size.
			hlba_pkg::ST_SO_RDI: begin
				if (i_q < gcount_q) begin
					gath_re = 1'b1;
					gath_raddr = i_q[IW-1:0];
					state_d = hlba_pkg::ST_SO_V;
				end else if (!by_size_q) begin
					state_d = hlba_pkg::ST_MG_RD0;
				end else begin
					i_d = '0;
					state_d = hlba_pkg::ST_BD_RD;
				end
			end

			hlba_pkg::ST_SO_V: begin
				v_d = gath_rd_q;
				j_d = i_q;
				gath_re = 1'b1;
				gath_raddr = IW'(i_q - 1'b1);
				state_d = hlba_pkg::ST_SO_CMP;
			end

			hlba_pkg::ST_SO_CMP: begin
				if (by_size_q) begin
					ahead = (e.size != v_q.size) ? (e.size > v_q.size) : (e.addr > v_q.addr);
				end else begin
					ahead = e.addr > v_q.addr;
				end
				gath_we = 1'b1;
				gath_waddr = j_q[IW-1:0];
				if (ahead) begin
					gath_wdata = e;
					j_d = j_q - 1'b1;
					if (j_q != CW'(1)) begin
						gath_re = 1'b1;
						gath_raddr = IW'(j_q - CW'(2));
					end else begin
						state_d = hlba_pkg::ST_SO_PUT;
					end
				end else begin
					gath_wdata = v_q;
					i_d = i_q + 1'b1;
					state_d = hlba_pkg::ST_SO_RDI;
				end
			end

			hlba_pkg::ST_SO_PUT: begin
				gath_we = 1'b1;
				gath_waddr = j_q[IW-1:0];
				gath_wdata = v_q;
				i_d = i_q + 1'b1;
				state_d = hlba_pkg::ST_SO_RDI;
			end

			// Merge holes that touch, walking the address-sorted list.
			hlba_pkg::ST_MG_RD0: begin
				gath_re = 1'b1;
				gath_raddr = '0;
				state_d = hlba_pkg::ST_MG_K0;
			end

			hlba_pkg::ST_MG_K0: begin
				k_d = gath_rd_q.addr;
				hole_re = 1'b1;
				hole_raddr = gath_rd_q.addr[PW-1:1];
				state_d = hlba_pkg::ST_MG_K1;
			end

			hlba_pkg::ST_MG_K1: begin
				l_d = hole_rd_q.size;
				knext_d = hole_rd_q.next;
				n_d = '0;
				i_d = CW'(1);
				state_d = hlba_pkg::ST_MG_RDI;
			end

			hlba_pkg::ST_MG_RDI: begin
				if (i_q < gcount_q) begin
					gath_re = 1'b1;
					gath_raddr = i_q[IW-1:0];
					state_d = hlba_pkg::ST_MG_P;
				end else begin
					hole_we = 1'b1;
					hole_waddr = k_q[PW-1:1];
					hole_wdata = '{next: knext_q, size: l_q};
					gath_we = 1'b1;
					gath_waddr = n_q[IW-1:0];
					gath_wdata = '{size: '0, addr: k_q};
					gcount_d = n_q + 1'b1;
					i_d = '0;
					state_d = hlba_pkg::ST_SF_RDI;
				end
			end

			hlba_pkg::ST_MG_P: begin
				p_d = gath_rd_q.addr;
				hole_re = 1'b1;
				hole_raddr = gath_rd_q.addr[PW-1:1];
				state_d = hlba_pkg::ST_MG_PD;
			end

			hlba_pkg::ST_MG_PD: begin
				if ((14'(k_q) + 14'(l_q)) == 14'(p_q)) begin
					l_d = l_q + hole_rd_q.size;
				end else begin
					hole_we = 1'b1;
					hole_waddr = k_q[PW-1:1];
					hole_wdata = '{next: knext_q, size: l_q};
					gath_we = 1'b1;
					gath_waddr = n_q[IW-1:0];
					gath_wdata = '{size: '0, addr: k_q};
					n_d = n_q + 1'b1;
					k_d = p_q;
					// A repeated address sees the size just written.
					l_d = (p_q == k_q) ? l_q : hole_rd_q.size;
					knext_d = hole_rd_q.next;
				end
				i_d = i_q + 1'b1;
				state_d = hlba_pkg::ST_MG_RDI;
			end

			// Attach each merged hole's size to its scratch entry.
			hlba_pkg::ST_SF_RDI: begin
				if (i_q < gcount_q) begin
					gath_re = 1'b1;
					gath_raddr = i_q[IW-1:0];
					state_d = hlba_pkg::ST_SF_A;
				end else begin
					i_d = CW'(1);
					by_size_d = 1'b1;
					state_d = hlba_pkg::ST_SO_RDI;
				end
			end

			hlba_pkg::ST_SF_A: begin
				p_d = gath_rd_q.addr;
				hole_re = 1'b1;
				hole_raddr = gath_rd_q.addr[PW-1:1];
				state_d = hlba_pkg::ST_SF_W;
			end

			hlba_pkg::ST_SF_W: begin
				gath_we = 1'b1;
				gath_waddr = i_q[IW-1:0];
				gath_wdata = '{size: hole_rd_q.size, addr: p_q};
				i_d = i_q + 1'b1;
				state_d = hlba_pkg::ST_SF_RDI;
			end

			// Rebuild the ready list, smallest pushed first.
			hlba_pkg::ST_BD_RD: begin
				if (i_q < gcount_q) begin
					gath_re = 1'b1;
					gath_raddr = i_q[IW-1:0];
					state_d = hlba_pkg::ST_BD_W;
				end else begin
					res_ok_d = 1'b1;
					state_d = hlba_pkg::ST_RES_RD;
				end
			end

			hlba_pkg::ST_BD_W: begin
				hole_we = 1'b1;
				hole_waddr = e.addr[PW-1:1];
				hole_wdata = '{next: ready_q, size: e.size};
				ready_d = e.addr;
				kept_d = kept_q + 1'b1;
				i_d = i_q + 1'b1;
				state_d = hlba_pkg::ST_BD_RD;
			end

			// Fetch the ready head's size for the status fields.
			hlba_pkg::ST_RES_RD: begin
				hole_re = 1'b1;
				hole_raddr = ready_q[PW-1:1];
				state_d = hlba_pkg::ST_RES;
			end

			hlba_pkg::ST_RES: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d = hlba_pkg::ST_IDLE;
				end
			end

			default: begin
				state_d = hlba_pkg::ST_IDLE;
			end
		endcase
	end

	// Hole descriptor memory.
	always_ff @(posedge clk) begin
		if (hole_we) begin
			hole_mem[hole_waddr] <= hole_wdata;
		end
		if (hole_re) begin
			hole_rd_q <= hole_mem[hole_raddr];
		end
	end

	// Scratch memory for reorganizing.
	always_ff @(posedge clk) begin
		if (gath_we) begin
			gath_mem[gath_waddr] <= gath_wdata;
		end
		if (gath_re) begin
			gath_rd_q <= gath_mem[gath_raddr];
		end
	end

	// Control and allocator state; a configuration write restarts the area.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hlba_pkg::ST_IDLE;
			list_q <= hlba_pkg::LS_FREED;
			area_q <= SW'(hlba_pkg::AREA_WORDS & ~1);
			bump_base_q <= '0;
			bump_size_q <= SW'(hlba_pkg::AREA_WORDS & ~1);
			ready_q <= hlba_pkg::NULL_PTR;
			freed_q <= hlba_pkg::NULL_PTR;
			dropped_q <= hlba_pkg::NULL_PTR;
			used_q <= '0;
			kept_q <= '0;
			gcount_q <= '0;
			i_q <= '0;
			j_q <= '0;
			n_q <= '0;
			by_size_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			list_q <= list_d;
			gcount_q <= gcount_d;
			i_q <= i_d;
			j_q <= j_d;
			n_q <= n_d;
			by_size_q <= by_size_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_write_enable) begin
				area_q <= cfg_area;
				bump_base_q <= '0;
				bump_size_q <= cfg_area;
				ready_q <= hlba_pkg::NULL_PTR;
				freed_q <= hlba_pkg::NULL_PTR;
				dropped_q <= hlba_pkg::NULL_PTR;
				used_q <= '0;
				kept_q <= '0;
			end else begin
				bump_base_q <= bump_base_d;
				bump_size_q <= bump_size_d;
				ready_q <= ready_d;
				freed_q <= freed_d;
				dropped_q <= dropped_d;
				used_q <= used_d;
				kept_q <= kept_d;
			end
		end
	end

	// Payload registers of the current item and the result.
	always_ff @(posedge clk) begin
		op_q <= op_d;
		rsz_q <= rsz_d;
		pos_q <= pos_d;
		res_ok_q <= res_ok_d;
		res_addr_q <= res_addr_d;
		walk_q <= walk_d;
		v_q <= v_d;
		k_q <= k_d;
		p_q <= p_d;
		knext_q <= knext_d;
		l_q <= l_d;
		if (out_load) begin
			ok_q <= res_ok_q;
			address_q <= res_addr_q;
			largest_q <= largest_bytes;
			used_out_q <= used_q;
			kept_out_q <= kept_q;
		end
	end

	assign out_valid = out_valid_q;
	assign ok = ok_q;
	assign address = address_q;
	assign largest_free_bytes = largest_q;
	assign used_words = used_out_q;
	assign hole_count = kept_out_q;

endmodule

`default_nettype wire

>>> tb/sv/hole_list_block_allocator_unit_test.sv
// Self-checking testbench for the hole-list block allocator unit.
// Tests allocate, free and reorganize against a predictor kept in the bench.
// Depends on hlba_pkg and hole_list_block_allocator_unit.
`default_nettype none

module hole_list_block_allocator_unit_test;

	localparam int unsigned NO_LINK = 32'hFFFF_FFFF;
	localparam int QUIET_LIMIT = 200000;
	// Operation code that the block does not know.
	localparam logic [1:0] OP_UNKNOWN = 2'd3;

	// Block ports.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] op = hlba_pkg::OP_ALLOC;
	logic [15:0] size_bytes = '0;
	logic [hlba_pkg::PTR_W-1:0] block_address = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	logic ok;
	logic [hlba_pkg::PTR_W-1:0] address;
	logic [15:0] largest_free_bytes;
	logic [hlba_pkg::SIZE_W-1:0] used_words;
	logic [hlba_pkg::CNT_W-1:0] hole_count;
	logic cfg_write_enable = 1'b0;
	logic [hlba_pkg::SIZE_W-1:0] cfg_write_data = '0;

	hole_list_block_allocator_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .size_bytes(size_bytes), .block_address(block_address),
		.out_valid(out_valid), .out_stall(out_stall),
		.ok(ok), .address(address), .largest_free_bytes(largest_free_bytes),
		.used_words(used_words), .hole_count(hole_count),
		.cfg_write_enable(cfg_write_enable), .cfg_write_data(cfg_write_data)
	);

	typedef struct {
		bit ok;
		bit [11:0] addr;
		bit [15:0] largest;
		bit [12:0] used;
		bit [11:0] holes;
	} outcome_t;

	typedef struct {
		int unsigned base;
		int unsigned words;
	} live_block_t;

	outcome_t pending_outcomes[$];
	live_block_t live_blocks[$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_req = 1'b0;
	int hold_cnt = 0;
	int quiet_cycles = 0;

	// Allocator mirror.
	int unsigned m_next[hlba_pkg::GRANULES];
	int unsigned m_size[hlba_pkg::GRANULES];
	int unsigned m_area, m_bump_base, m_bump_size;
	int unsigned m_ready, m_freed, m_dropped, m_used, m_holes;
	int unsigned scratch[hlba_pkg::GRANULES];
	int unsigned scratch_n;

	// Clock.
	initial begin
		forever #5 clk = ~clk;
	end

	function automatic bit in_range(int unsigned a);
		return a != NO_LINK && (a >> 1) < hlba_pkg::GRANULES;
	endfunction

	function automatic int unsigned nxt_of(int unsigned a);
		return in_range(a) ? m_next[a >> 1] : NO_LINK;
	endfunction

	function automatic int unsigned sz_of(int unsigned a);
		return in_range(a) ? m_size[a >> 1] : 0;
	endfunction

	function automatic void put_link(int unsigned a, int unsigned n, int unsigned s);
		if (in_range(a)) begin
			m_next[a >> 1] = n;
			m_size[a >> 1] = s & 32'h1FFF;
		end
	endfunction

	function automatic int unsigned granule_words(int unsigned bytes);
		return ((bytes + hlba_pkg::GRAN_BYTES - 1) / hlba_pkg::GRAN_BYTES) * 2;
	endfunction

	function automatic void clear_area();
		foreach (m_next[i]) begin
			m_next[i] = 0;
			m_size[i] = 0;
		end
		m_bump_base = 0;
		m_bump_size = m_area;
		m_ready = NO_LINK;
		m_freed = NO_LINK;
		m_dropped = NO_LINK;
		m_used = 0;
		m_holes = 0;
		live_blocks.delete();
	endfunction

	function automatic void set_area(int unsigned v);
		v = v & 32'h1FFF;
		if (v > hlba_pkg::AREA_WORDS)
			v = hlba_pkg::AREA_WORDS;
		m_area = v & ~32'd1;
		clear_area();
	endfunction

	function automatic void collect(int unsigned a);
		while (in_range(a) && scratch_n < hlba_pkg::GRANULES) begin
			scratch[scratch_n] = a;
			scratch_n++;
			a = nxt_of(a);
		end
	endfunction

	// Bigger first; equal sizes keep the higher address ahead.
	function automatic bit ranks_above(int unsigned a, int unsigned b);
		int unsigned sa, sb;
		sa = sz_of(a);
		sb = sz_of(b);
		return sa != sb ? sa > sb : a > b;
	endfunction

	function automatic void sort_scratch(bit by_size);
		int unsigned j, v;
		for (int unsigned i = 1; i < scratch_n; i++) begin
			v = scratch[i];
			j = i;
			while (j > 0 && (by_size ? ranks_above(scratch[j-1], v) : scratch[j-1] > v)) begin
				scratch[j] = scratch[j-1];
				j--;
			end
			scratch[j] = v;
		end
	endfunction

	function automatic bit merge_holes();
		int unsigned n, k, l, p;
		scratch_n = 0;
		collect(m_freed);
		collect(m_dropped);
		if (scratch_n == 0)
			return 1'b0;
		collect(m_ready);
		m_ready = NO_LINK;
		m_freed = NO_LINK;
		m_dropped = NO_LINK;
		m_holes = 0;
		sort_scratch(1'b0);
		n = 0;
		k = scratch[0];
		l = sz_of(k);
		for (int unsigned i = 1; i < scratch_n; i++) begin
			p = scratch[i];
			if (k + l == p) begin
				l = (l + sz_of(p)) & 32'h1FFF;
			end else begin
				put_link(k, nxt_of(k), l);
				scratch[n] = k;
				n++;
				k = p;
				l = sz_of(p);
			end
		end
		put_link(k, nxt_of(k), l);
		scratch[n] = k;
		n++;
		scratch_n = n;
		sort_scratch(1'b1);
		for (int unsigned i = 0; i < scratch_n; i++) begin
			put_link(scratch[i], m_ready, sz_of(scratch[i]));
			m_ready = scratch[i];
			m_holes = (m_holes + 1) & 32'hFFF;
		end
		return 1'b1;
	endfunction

	function automatic bit take_block(int unsigned rsz, output int unsigned a);
		int unsigned hs, rem, nx;
		a = 0;
		if (rsz == 0)
			return 1'b0;
		if (rsz <= m_bump_size) begin
			m_bump_size -= rsz;
			a = m_bump_base + m_bump_size;
		end else if (in_range(m_ready) && rsz <= sz_of(m_ready)) begin
			hs = sz_of(m_ready);
			if (rsz == hs) begin
				a = m_ready;
				m_ready = nxt_of(m_ready);
				m_holes = (m_holes - 1) & 32'hFFF;
			end else begin
				// Retire the current bump hole before the ready head replaces it.
				if (m_bump_size != 0) begin
					put_link(m_bump_base, m_dropped, m_bump_size);
					m_dropped = m_bump_base;
					m_holes = (m_holes + 1) & 32'hFFF;
				end
				m_bump_base = m_ready;
				m_bump_size = hs - rsz;
				m_ready = nxt_of(m_ready);
				m_holes = (m_holes - 1) & 32'hFFF;
				a = m_bump_base + m_bump_size;
			end
		end else if (in_range(m_freed) && rsz <= sz_of(m_freed)) begin
			a = m_freed;
			rem = sz_of(m_freed) - rsz;
			nx = nxt_of(m_freed);
			if (rem > 0) begin
				m_freed += rsz;
				put_link(m_freed, nx, rem);
			end else begin
				m_freed = nx;
				m_holes = (m_holes - 1) & 32'hFFF;
			end
		end else begin
			return 1'b0;
		end
		m_used = (m_used + rsz) & 32'h1FFF;
		return 1'b1;
	endfunction

	function automatic bit give_back(int unsigned pos, int unsigned rsz);
		if (pos[0] || pos >= m_area || rsz == 0 || pos + rsz > m_area || rsz > m_used)
			return 1'b0;
		m_used -= rsz;
		if (m_bump_base + m_bump_size == pos) begin
			m_bump_size = (m_bump_size + rsz) & 32'h1FFF;
		end else if (m_freed != NO_LINK && pos + rsz == m_freed) begin
			put_link(pos, nxt_of(m_freed), sz_of(m_freed) + rsz);
			m_freed = pos;
		end else if (in_range(m_freed) && m_freed + sz_of(m_freed) == pos) begin
			put_link(m_freed, nxt_of(m_freed), sz_of(m_freed) + rsz);
		end else begin
			put_link(pos, m_freed, rsz);
			m_freed = pos;
			m_holes = (m_holes + 1) & 32'hFFF;
		end
		return 1'b1;
	endfunction

	function automatic outcome_t predict_outcome(logic [1:0] o, int unsigned bytes,
			int unsigned pos);
		outcome_t r;
		int unsigned rsz, a, big;
		rsz = granule_words(bytes);
		a = 0;
		r.ok = 1'b0;
		case (o)
			hlba_pkg::OP_ALLOC: begin
				r.ok = take_block(rsz, a);
				if (!r.ok)
					a = 0;
			end
			hlba_pkg::OP_FREE: r.ok = give_back(pos, rsz);
			hlba_pkg::OP_REORG: r.ok = merge_holes();
			default: r.ok = 1'b0;
		endcase
		big = m_bump_size;
		if (in_range(m_ready) && sz_of(m_ready) > big)
			big = sz_of(m_ready);
		r.addr = a[11:0];
		r.largest = 16'((big * hlba_pkg::BYTES_PER_WORD) & 32'hFFFF);
		r.used = m_used[12:0];
		r.holes = m_holes[11:0];
		return r;
	endfunction

	// Sends one item, then records its predicted outcome once the transfer is taken.
	task automatic send_item(logic [1:0] o, int unsigned bytes, int unsigned pos);
		outcome_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		op <= o;
		size_bytes <= bytes[15:0];
		block_address <= pos[11:0];
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		r = predict_outcome(o, bytes, pos);
		pending_outcomes.push_back(r);
		if (o == hlba_pkg::OP_ALLOC && r.ok)
			live_blocks.push_back('{base: r.addr, words: granule_words(bytes)});
	endtask

	// Drops the input, drains all outcomes and lets the block settle.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_area(int unsigned v);
		drain();
		cfg_write_enable <= 1'b1;
		cfg_write_data <= v[12:0];
		@(posedge clk);
		cfg_write_enable <= 1'b0;
		set_area(v);
	endtask

	// Frees a random live block with a byte count that rounds to its size.
	task automatic free_live();
		int idx;
		live_block_t b;
		idx = $urandom_range(live_blocks.size() - 1);
		b = live_blocks[idx];
		live_blocks.delete(idx);
		send_item(hlba_pkg::OP_FREE,
			(b.words / 2 - 1) * hlba_pkg::GRAN_BYTES + $urandom_range(1, hlba_pkg::GRAN_BYTES),
			b.base);
	endtask

	task automatic random_item();
		int unsigned pick, bytes;
		pick = $urandom_range(99);
		if (live_blocks.size() > 60 && pick < 55)
			pick = 60;
		if (pick < 55) begin
			case ($urandom_range(19))
				0: bytes = $urandom_range(65535);
				1: bytes = 0;
				default: bytes = $urandom_range(1, 300);
			endcase
			send_item(hlba_pkg::OP_ALLOC, bytes, $urandom_range(4095));
		end else if (pick < 88) begin
			if (live_blocks.size() != 0)
				free_live();
			else
				send_item(hlba_pkg::OP_ALLOC, $urandom_range(1, 200), $urandom_range(4095));
		end else if (pick < 94) begin
			send_item(hlba_pkg::OP_REORG, $urandom_range(65535), $urandom_range(4095));
		end else if (pick < 98) begin
			// Odd address: always refused, whatever the size.
			send_item(hlba_pkg::OP_FREE, $urandom_range(65535), $urandom_range(4095) | 1);
		end else begin
			send_item(OP_UNKNOWN, $urandom_range(65535), $urandom_range(4095));
		end
	endtask

	// Receiver: random stalls, a counted hold-off on request, and the result check.
	always @(posedge clk) begin
		outcome_t e;
		if (out_valid && !out_stall) begin
			if (pending_outcomes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: ok=%0d address=%0d", ok, address);
			end else begin
				e = pending_outcomes.pop_front();
				if (ok !== e.ok || address !== e.addr || largest_free_bytes !== e.largest ||
						used_words !== e.used || hole_count !== e.holes) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp ok=%0d addr=%0d lfb=%0d used=%0d holes=%0d,",
							" got ok=%0d addr=%0d lfb=%0d used=%0d holes=%0d"},
							e.ok, e.addr, e.largest, e.used, e.holes,
							ok, address, largest_free_bytes, used_words, hole_count);
				end
			end
		end
		if (hold_req) begin
			hold_req <= 1'b0;
			hold_cnt <= 300;
			out_stall <= 1'b1;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= $urandom_range(99) < recv_idle_pct;
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic test_directed();
		send_item(hlba_pkg::OP_REORG, 0, 0);
		send_item(hlba_pkg::OP_ALLOC, 0, 0);
		send_item(hlba_pkg::OP_ALLOC, 65535, 4095);
		send_item(hlba_pkg::OP_ALLOC, 32768, 0);
		send_item(hlba_pkg::OP_ALLOC, 16, 0);
		send_item(hlba_pkg::OP_FREE, 32768, 0);
		send_item(hlba_pkg::OP_ALLOC, 100, 0);
		send_item(hlba_pkg::OP_ALLOC, 48, 0);
		send_item(hlba_pkg::OP_ALLOC, 1, 0);
		send_item(hlba_pkg::OP_FREE, 16, 4095);
		send_item(hlba_pkg::OP_FREE, 0, 4080);
		send_item(hlba_pkg::OP_FREE, 64, 4094);
		send_item(hlba_pkg::OP_FREE, 32768, 4080);
		send_item(hlba_pkg::OP_FREE, 48, 4082);
		send_item(hlba_pkg::OP_FREE, 16, 4080);
		send_item(OP_UNKNOWN, 65535, 4095);
		send_item(hlba_pkg::OP_REORG, 0, 0);
		send_item(hlba_pkg::OP_ALLOC, 48, 0);
		send_item(hlba_pkg::OP_ALLOC, 32, 0);
		send_item(hlba_pkg::OP_REORG, 65535, 4095);
		live_blocks.delete();
	endtask

	task automatic test_random(int items, int s_pct, int r_pct);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		repeat (items) random_item();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req = 1'b1;
		repeat (30) random_item();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		set_area(hlba_pkg::AREA_WORDS);
		test_directed();
		test_random(550, 35, 86);
		write_area(1000);
		test_random(550, 86, 35);
		write_area(8191);
		test_backpressure();
		write_area(64);
		test_random(250, 0, 0);
		write_area(7);
		test_random(40, 0, 0);
		write_area(0);
		test_random(20, 0, 0);
		write_area(hlba_pkg::AREA_WORDS);
		test_random(250, 0, 0);
		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
